/* hdl/cfar_pkg.sv */
// ----------------------------------------------------------------------------
// CFAR package
// Item types, register indexes, detector modes and the evaluator control word.
// ----------------------------------------------------------------------------
package cfar_pkg;

	typedef struct packed {
		logic [7:0] sample;
		logic       beam_end;
	} smp_item_t;

	typedef struct packed {
		logic detect;
		logic last;
	} det_item_t;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	localparam logic [CFG_IDX_W-1:0] REG_MODE       = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TRAIN_HALF = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GUARD_HALF = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_RANK       = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_TAU        = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_GATE       = 3'd5;

	localparam logic [1:0] MODE_CA   = 2'd0;
	localparam logic [1:0] MODE_SOCA = 2'd1;
	localparam logic [1:0] MODE_GOCA = 2'd2;
	localparam logic [1:0] MODE_OS   = 2'd3;

	// control from the sequencer to the evaluator
	typedef struct packed {
		logic       clear;
		logic       step;
		logic       pass_end;
		logic [2:0] bit_idx;
		logic       mul;
	} eval_ctl_t;

endpackage

/* hdl/cfar_range_detector.sv */
// ----------------------------------------------------------------------------
// CFAR range detector
// CA / SOCA / GOCA / OS CFAR over a sliding window of range samples.
// ----------------------------------------------------------------------------
// Sequence: an item whose cell is evaluated is swept past the evaluator in
//   passes (1 pass, 8 for OS), then goes through ST_MUL and ST_CMP to ST_EMIT.
// Intake: one item at a time, taken only in ST_IDLE; results wait for det_ready.
//   Items with no evaluation go straight to ST_EMIT, or stay idle if they give none.
// Reset: asynchronous; clears the window, beam position and state, loads config defaults.
module cfar_range_detector #(
	parameter int TRAIN_HALF_MAX  = 32,
	parameter int BORDER_MAX      = 63,
	parameter int BEAM_LENGTH_MAX = 4096
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                smp_valid,
	output logic                                smp_ready,
	input  cfar_pkg::smp_item_t                 smp,
	output logic                                det_valid,
	input  logic                                det_ready,
	output cfar_pkg::det_item_t                 det,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [cfar_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [cfar_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import cfar_pkg::*;

	localparam int THCAP = (TRAIN_HALF_MAX < BORDER_MAX) ? TRAIN_HALF_MAX : BORDER_MAX;
	localparam int DEPTH = 2 * BORDER_MAX + 1;
	localparam int BW    = $clog2(BORDER_MAX + 1);
	localparam int KW    = $clog2(DEPTH);
	localparam int SW    = $clog2(THCAP * 255 + 1);
	localparam int CNTW  = $clog2(2 * THCAP + 1);
	localparam int PW    = $clog2(BEAM_LENGTH_MAX);
	localparam int NW    = $clog2(BORDER_MAX + 2);
	localparam int CW    = ((PW > KW) ? PW : KW) + 1;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_SWEEP = 5'b00010,
		ST_MUL   = 5'b00100,
		ST_CMP   = 5'b01000,
		ST_EMIT  = 5'b10000
	} state_t;

	state_t        state_q;
	logic [1:0]    mode_q;
	logic [5:0]    train_half_q, rank_q;
	logic [4:0]    guard_half_q;
	logic [23:0]   tau_q;
	logic [7:0]    gate_q;
	logic [PW-1:0] pos_q;
	logic [NW-1:0] n_q;
	logic          end_q, det_q;
	logic [KW-1:0] k_q;
	logic [2:0]    pass_q;

	logic [BW-1:0] th, gmax, g, border;
	logic [KW-1:0] bord2, lead_lo;
	logic          accept, last_k, last_pass, reload, sweep, detect;
	logic [CW-1:0] p_ext, p1;
	logic          due, full;
	logic [BW-1:0] f;
	logic [NW-1:0] n_new;
	eval_ctl_t     ctl;
	logic [7:0]    win_w  [DEPTH];
	logic [7:0]    scan_w [DEPTH];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= MODE_CA;
			train_half_q <= 6'd8;
			guard_half_q <= 5'd2;
			rank_q       <= 6'd8;
			tau_q        <= 24'd65536;
			gate_q       <= 8'd0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_MODE:       mode_q       <= cfg_data[1:0];
				REG_TRAIN_HALF: train_half_q <= cfg_data[5:0];
				REG_GUARD_HALF: guard_half_q <= cfg_data[4:0];
				REG_RANK:       rank_q       <= cfg_data[5:0];
				REG_TAU:        tau_q        <= cfg_data[23:0];
				REG_GATE:       gate_q       <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// effective window geometry
	always_comb begin
		if (train_half_q == 6'd0) begin
			th = BW'(1);
		end else if (32'(train_half_q) > THCAP) begin
			th = BW'(THCAP);
		end else begin
			th = BW'(train_half_q);
		end
		gmax = BW'(BORDER_MAX) - th;
		g    = (32'(guard_half_q) > 32'(gmax)) ? gmax : BW'(guard_half_q);
	end

	assign border  = th + g;
	assign bord2   = KW'({border, 1'b0});
	assign lead_lo = KW'(border) + KW'(g) + KW'(1);

	assign smp_ready = (state_q == ST_IDLE);
	assign accept    = smp_valid && smp_ready;
	assign sweep     = (state_q == ST_SWEEP);
	assign last_k    = (k_q == bord2);
	assign last_pass = (mode_q == MODE_OS) ? (pass_q == 3'd7) : 1'b1;
	assign reload    = sweep && last_k && !last_pass;

	assign p_ext = CW'(pos_q);
	assign p1    = p_ext + CW'(1);
	assign due   = p_ext >= CW'(border);
	assign full  = p_ext >= CW'(bord2);
	assign f     = (p1 < CW'(border)) ? BW'(p1) : border;
	assign n_new = NW'(due) + (smp.beam_end ? NW'(f) : NW'(0));

	always_comb begin
		ctl.clear    = accept;
		ctl.step     = sweep;
		ctl.pass_end = sweep && last_k;
		ctl.bit_idx  = 3'd7 - pass_q;
		ctl.mul      = (state_q == ST_MUL);
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [7:0] w_in, s_in;
		if (i == 0) begin : g_head
			assign w_in = smp.sample;
		end else begin : g_body
			assign w_in = win_w[i-1];
		end
		if (i == DEPTH - 1) begin : g_tail
			assign s_in = 8'd0;
		end else begin : g_link
			assign s_in = scan_w[i+1];
		end
		cfar_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.shift  (accept),
			.load   (reload),
			.step   (sweep),
			.win_in (w_in),
			.scan_in(s_in),
			.win    (win_w[i]),
			.scan   (scan_w[i])
		);
	end

	cfar_eval #(
		.BW  (BW),
		.KW  (KW),
		.SW  (SW),
		.CNTW(CNTW)
	) u_eval (
		.clk    (clk),
		.ctl    (ctl),
		.head   (scan_w[0]),
		.k      (k_q),
		.th     (th),
		.border (KW'(border)),
		.lead_lo(lead_lo),
		.mode   (mode_q),
		.rank   (rank_q),
		.tau    (tau_q),
		.gate   (gate_q),
		.detect (detect)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pos_q   <= '0;
			n_q     <= '0;
			end_q   <= 1'b0;
			det_q   <= 1'b0;
			k_q     <= '0;
			pass_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						end_q  <= smp.beam_end;
						n_q    <= n_new;
						det_q  <= 1'b0;
						k_q    <= '0;
						pass_q <= '0;
						if (smp.beam_end) begin
							pos_q <= '0;
						end else if (pos_q != PW'(BEAM_LENGTH_MAX - 1)) begin
							pos_q <= pos_q + PW'(1);
						end
						if (n_new == '0) begin
							state_q <= ST_IDLE;
						end else if (full) begin
							state_q <= ST_SWEEP;
						end else begin
							state_q <= ST_EMIT;
						end
					end
				end
				ST_SWEEP: begin
					if (last_k) begin
						k_q <= '0;
						if (last_pass) begin
							state_q <= ST_MUL;
						end else begin
							pass_q <= pass_q + 3'd1;
						end
					end else begin
						k_q <= k_q + KW'(1);
					end
				end
				ST_MUL: begin
					state_q <= ST_CMP;
				end
				ST_CMP: begin
					det_q   <= detect;
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (det_ready) begin
						det_q <= 1'b0;
						n_q   <= n_q - NW'(1);
						if (n_q == NW'(1)) state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign det_valid  = (state_q == ST_EMIT);
	assign det.detect = det_q;
	assign det.last   = end_q && (n_q == NW'(1));
endmodule

/* hdl/cfar_cell.sv */
// ----------------------------------------------------------------------------
// CFAR window cell
// One tap of the range window plus one tap of the scan line that walks a copy
// of the window past the evaluator.
// ----------------------------------------------------------------------------
module cfar_cell (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       shift,
	input  logic       load,
	input  logic       step,
	input  logic [7:0] win_in,
	input  logic [7:0] scan_in,
	output logic [7:0] win,
	output logic [7:0] scan
);
	logic [7:0] win_q;
	logic [7:0] scan_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
		end else if (shift) begin
			win_q <= win_in;
		end
	end

	always_ff @(posedge clk) begin
		if (shift) begin
			scan_q <= win_in;
		end else if (load) begin
			scan_q <= win_q;
		end else if (step) begin
			scan_q <= scan_in;
		end
	end

	assign win  = win_q;
	assign scan = scan_q;
endmodule

/* hdl/cfar_eval.sv */
// ----------------------------------------------------------------------------
// CFAR evaluator
// Accumulates training sums and a radix select of the ordered statistic from
// the scan head, then cross-multiplies against tau and compares the cell with the gate.
// ----------------------------------------------------------------------------
module cfar_eval #(
	parameter int BW   = 6,
	parameter int KW   = 7,
	parameter int SW   = 13,
	parameter int CNTW = 7
) (
	input  logic                  clk,
	input  cfar_pkg::eval_ctl_t   ctl,
	input  logic [7:0]            head,
	input  logic [KW-1:0]         k,
	input  logic [BW-1:0]         th,
	input  logic [KW-1:0]         border,
	input  logic [KW-1:0]         lead_lo,
	input  logic [1:0]            mode,
	input  logic [5:0]            rank,
	input  logic [23:0]           tau,
	input  logic [7:0]            gate,
	output logic                  detect
);
	import cfar_pkg::*;

	localparam int OW = SW + 1;
	localparam int LW = 8 + BW + 1;
	localparam int RW = 24 + OW;
	localparam int MW = RW + LW + 16;

	logic [SW-1:0]   lag_q, lead_q;
	logic [7:0]      cell_q;
	logic [7:0]      prefix_q;
	logic [CNTW-1:0] cnt_q, rem_q;
	logic [CNTW-1:0] cnt_next, rank_lim, rank_eff;
	logic [8:0]      mask9;
	logic [7:0]      mask;
	logic            is_lag, is_lead, hit;
	logic [OW-1:0]   sum_all, sum_min, sum_max, operand;
	logic [BW:0]     factor;
	logic [RW-1:0]   prod_r_s1;
	logic [LW-1:0]   prod_l_s1;

	assign is_lag   = KW'(th) > k;
	assign is_lead  = k >= lead_lo;
	assign mask9    = 9'h1FF << (4'(ctl.bit_idx) + 4'd1);
	assign mask     = mask9[7:0];
	assign hit      = (is_lag || is_lead) && ((head & mask) == (prefix_q & mask))
	                  && !head[ctl.bit_idx];
	assign cnt_next = cnt_q + CNTW'(hit);

	assign rank_lim = CNTW'({th, 1'b0}) - CNTW'(1);
	assign rank_eff = (CNTW'(rank) > rank_lim) ? rank_lim : CNTW'(rank);

	always_ff @(posedge clk) begin
		if (ctl.clear) begin
			lag_q    <= '0;
			lead_q   <= '0;
			cnt_q    <= '0;
			prefix_q <= '0;
			rem_q    <= rank_eff;
		end else if (ctl.step) begin
			if (ctl.bit_idx == 3'd7) begin
				if (is_lag)  lag_q  <= lag_q + SW'(head);
				if (is_lead) lead_q <= lead_q + SW'(head);
			end
			if (k == border) cell_q <= head;
			if (ctl.pass_end) begin
				cnt_q <= '0;
				if (rem_q >= cnt_next) begin
					prefix_q[ctl.bit_idx] <= 1'b1;
					rem_q <= rem_q - cnt_next;
				end
			end else begin
				cnt_q <= cnt_next;
			end
		end
	end

	assign sum_all = OW'(lag_q) + OW'(lead_q);
	assign sum_min = (lead_q < lag_q) ? OW'(lead_q) : OW'(lag_q);
	assign sum_max = (lead_q > lag_q) ? OW'(lead_q) : OW'(lag_q);

	always_comb begin
		case (mode)
			MODE_CA: begin
				operand = sum_all;
				factor  = {th, 1'b0};
			end
			MODE_SOCA: begin
				operand = sum_min;
				factor  = (BW+1)'(th);
			end
			MODE_GOCA: begin
				operand = sum_max;
				factor  = (BW+1)'(th);
			end
			default: begin
				operand = OW'(prefix_q);
				factor  = (BW+1)'(1);
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctl.mul) begin
			prod_r_s1 <= RW'(tau) * RW'(operand);
			prod_l_s1 <= LW'(cell_q) * LW'(factor);
		end
	end

	assign detect = (MW'({prod_l_s1, 16'h0000}) > MW'(prod_r_s1)) && (cell_q > gate);
endmodule

/* hdl/cfar_checker.sv */
// ----------------------------------------------------------------------------
// CFAR checker
// Port-level checks of the range detector, bound to the top level.
// ----------------------------------------------------------------------------
module cfar_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                smp_valid,
	input logic                smp_ready,
	input cfar_pkg::smp_item_t smp,
	input logic                det_valid,
	input logic                det_ready,
	input cfar_pkg::det_item_t det
);
	// one item at a time: no intake while a result is shown
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(smp_ready && det_valid)) else $error("intake open while result shown");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		det_valid && !det_ready |=> det_valid) else $error("result dropped");

	a_end_busy: assert property (@(posedge clk) disable iff (!arst_n)
		smp_valid && smp_ready && smp.beam_end |=> !smp_ready)
		else $error("beam end gave no result");

	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		det_valid && det_ready && det.last |=> smp_ready)
		else $error("not idle after last item");
endmodule

bind cfar_range_detector cfar_checker u_cfar_checker (.*);
